// File: hdl/sliding_window_median_core_assert.svh
// assertion macros for the sliding window median core
`ifndef SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SWM_ASSERT_IMP(lbl, ante, cons, msg)

`define SWM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/swm_pkg.sv
// shared types and constants of the sliding window median filter
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  localparam int MAX_WINDOW_DEF = 64;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  // register index codes
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // status one cell shows its neighbors
  typedef struct packed {
    logic valid;  // entry holds a sample
    logic gt;     // entry sorts after the incoming sample (or is empty)
    logic old;    // entry leaves the window on this beat
  } swm_stat_t;

endpackage

// File: hdl/swm_cell.sv
// one cell of the sorted window: holds a sample and its age
module swm_cell #(
  parameter int AGE_W = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic                           load,
  input  logic                           full,
  input  logic [AGE_W-1:0]               oldest_age,
  input  logic signed [swm_pkg::DATA_W-1:0] sample,
  input  logic signed [swm_pkg::DATA_W-1:0] lo_value,
  input  logic [AGE_W-1:0]               lo_age,
  input  swm_pkg::swm_stat_t             lo_stat,
  input  logic                           lo_del,
  input  logic signed [swm_pkg::DATA_W-1:0] hi_value,
  input  logic [AGE_W-1:0]               hi_age,
  input  swm_pkg::swm_stat_t             hi_stat,
  input  logic                           self_del,
  output logic signed [swm_pkg::DATA_W-1:0] value,
  output logic [AGE_W-1:0]               age,
  output swm_pkg::swm_stat_t             stat
);

  logic                              valid;
  logic signed [swm_pkg::DATA_W-1:0] value_next;
  logic [AGE_W-1:0]                  age_next;
  logic                              valid_next;

  // contents after the leaving entry is squeezed out, at this place and one below
  logic signed [swm_pkg::DATA_W-1:0] c_self_value, c_lo_value;
  logic [AGE_W-1:0]                  c_self_age, c_lo_age;
  logic                              c_self_valid, c_lo_valid;
  logic                              c_self_gt, c_lo_gt;

  assign stat.valid = valid;
  assign stat.gt    = !valid || (value > sample);
  assign stat.old   = valid && full && (age == oldest_age);

  always_comb begin
    c_self_value = self_del ? hi_value       : value;
    c_self_age   = self_del ? hi_age         : age;
    c_self_valid = self_del ? hi_stat.valid  : valid;
    c_self_gt    = self_del ? hi_stat.gt     : stat.gt;
    c_lo_value   = lo_del   ? value          : lo_value;
    c_lo_age     = lo_del   ? age            : lo_age;
    c_lo_valid   = lo_del   ? valid          : lo_stat.valid;
    c_lo_gt      = lo_del   ? stat.gt        : lo_stat.gt;

    if (!c_self_gt) begin
      value_next = c_self_value;
      age_next   = c_self_age + AGE_W'(1);
      valid_next = c_self_valid;
    end else if (!c_lo_gt) begin
      // new sample lands here
      value_next = sample;
      age_next   = '0;
      valid_next = 1'b1;
    end else begin
      value_next = c_lo_value;
      age_next   = c_lo_age + AGE_W'(1);
      valid_next = c_lo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

// File: hdl/sliding_window_median_core.sv
// sliding window median filter: a row of sorted cells with a registered median output
// Takes one sample per clock and, once window_size samples have arrived, gives the
// lower median of the last window_size samples for every sample. Each sample updates
// the whole row of cells at the edge that takes it (drop oldest, insert in order); the
// median is read from the row into the output register once that register is free, so
// without output stalls a result is offered from the clock edge after the one that
// takes its sample. Input stalls only while a result waits and the output register
// is still held. Writing window_size empties the window.
module sliding_window_median_core #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  // median stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] median
);

  `include "sliding_window_median_core_assert.svh"

  localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int WW    = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;

  logic [swm_pkg::CFG_W-1:0] window_size;
  logic [CNT_W-1:0]          fill;
  logic [CNT_W-1:0]          weff;
  logic [WW-1:0]             win_wide;
  logic [AGE_W-1:0]          oldest_age;
  logic [AGE_W-1:0]          mid;
  logic                      full;
  logic                      cfg_write;
  logic                      accept;
  logic                      out_free;
  logic                      emit_pend;
  logic                      emit_new;

  logic signed [swm_pkg::DATA_W-1:0] sample;
  logic signed [swm_pkg::DATA_W-1:0] cell_value [MAX_WINDOW];
  logic [AGE_W-1:0]                  cell_age   [MAX_WINDOW];
  swm_pkg::swm_stat_t                cell_stat  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]             old_vec;
  logic [MAX_WINDOW-1:0]             valid_vec;
  logic [MAX_WINDOW-1:0]             del_vec;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      swm_pkg::REG_WINDOW_SIZE: prdata = {{(32 - swm_pkg::CFG_W){1'b0}}, window_size};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WINDOW_RESET;
    end else if (cfg_write && paddr[2] == swm_pkg::REG_WINDOW_SIZE) begin
      window_size <= pwdata[swm_pkg::CFG_W-1:0];
    end
  end

  // effective window: zero means one, above the row length saturates
  assign win_wide = WW'(window_size);
  always_comb begin
    if (win_wide == '0) begin
      weff = CNT_W'(1);
    end else if (win_wide > WW'(MAX_WINDOW)) begin
      weff = CNT_W'(MAX_WINDOW);
    end else begin
      weff = CNT_W'(win_wide);
    end
  end

  assign oldest_age = AGE_W'(weff - CNT_W'(1));
  assign mid        = oldest_age >> 1;
  assign full       = (fill == weff);

  // handshake
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !emit_pend || out_free;
  assign accept   = s_tvalid && s_tready;
  assign sample   = $signed(s_tdata);
  assign emit_new = full || (fill + CNT_W'(1) == weff);

  always_ff @(posedge clk) begin
    if (rst || (cfg_write && paddr[2] == swm_pkg::REG_WINDOW_SIZE)) begin
      fill <= '0;
    end else if (accept && !full) begin
      fill <= fill + CNT_W'(1);
    end
  end

  // cell row
  genvar i;
  generate
    for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic signed [swm_pkg::DATA_W-1:0] lo_value, hi_value;
      logic [AGE_W-1:0]                  lo_age, hi_age;
      swm_pkg::swm_stat_t                lo_stat, hi_stat;
      logic                              lo_del;

      assign old_vec[i]   = cell_stat[i].old;
      assign valid_vec[i] = cell_stat[i].valid;
      assign del_vec[i]   = |old_vec[i:0];

      if (i == 0) begin : g_lo_edge
        assign lo_value = '0;
        assign lo_age   = '0;
        assign lo_stat  = '{valid: 1'b0, gt: 1'b0, old: 1'b0};
        assign lo_del   = 1'b0;
      end else begin : g_lo
        assign lo_value = cell_value[i-1];
        assign lo_age   = cell_age[i-1];
        assign lo_stat  = cell_stat[i-1];
        assign lo_del   = del_vec[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_hi_edge
        assign hi_value = '0;
        assign hi_age   = '0;
        assign hi_stat  = '{valid: 1'b0, gt: 1'b1, old: 1'b0};
      end else begin : g_hi
        assign hi_value = cell_value[i+1];
        assign hi_age   = cell_age[i+1];
        assign hi_stat  = cell_stat[i+1];
      end

      swm_cell #(
        .AGE_W (AGE_W)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .clear      (cfg_write && paddr[2] == swm_pkg::REG_WINDOW_SIZE),
        .load       (accept),
        .full       (full),
        .oldest_age (oldest_age),
        .sample     (sample),
        .lo_value   (lo_value),
        .lo_age     (lo_age),
        .lo_stat    (lo_stat),
        .lo_del     (lo_del),
        .hi_value   (hi_value),
        .hi_age     (hi_age),
        .hi_stat    (hi_stat),
        .self_del   (del_vec[i]),
        .value      (cell_value[i]),
        .age        (cell_age[i]),
        .stat       (cell_stat[i])
      );
    end
  endgenerate

  // median read and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        emit_pend <= emit_new;
      end else if (out_free) begin
        emit_pend <= 1'b0;
      end
      if (emit_pend && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pend && out_free) begin
      m_tdata <= cell_value[mid];
    end
  end

  `SWM_ASSERT_IMP(a_fill_in_window, 1'b1, fill <= weff, "fill beyond window")
  `SWM_ASSERT_IMP(a_fill_matches_cells, 1'b1, $countones(valid_vec) == fill, "fill and cells disagree")
  `SWM_ASSERT_IMP(a_cells_packed, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0, "gap in cell row")
  `SWM_ASSERT_IMP(a_one_leaves, accept && full, $onehot(old_vec), "not exactly one oldest entry")
  `SWM_ASSERT_NXT(a_full_emits, accept && full, emit_pend, "full window gave no result")

endmodule

// File: bench/tb_sliding_window_median_core.sv
// self-checking testbench for the sliding window median filter core
`timescale 1ns / 100ps

class median_scoreboard;
  logic [31:0] win_vals [swm_pkg::MAX_WINDOW_DEF];
  int          win_ages [swm_pkg::MAX_WINDOW_DEF];
  int          fill;
  int          win_cfg;
  logic [31:0] medians_due [$];
  int          errors;
  int          samples_seen;
  int          medians_seen;

  function new();
    fill         = 0;
    win_cfg      = int'(swm_pkg::WINDOW_RESET);
    errors       = 0;
    samples_seen = 0;
    medians_seen = 0;
  endfunction

  function void write_reg(int index, logic [31:0] value);
    if (index == int'(swm_pkg::REG_WINDOW_SIZE)) begin
      win_cfg = int'(value[6:0]);
      fill    = 0;
    end
  endfunction

  function int pending();
    return medians_due.size();
  endfunction

  function void note_sample(logic [31:0] x);
    int w;
    int pos;
    int i;
    w = (win_cfg == 0) ? 1 : win_cfg;
    if (w > swm_pkg::MAX_WINDOW_DEF) w = swm_pkg::MAX_WINDOW_DEF;
    samples_seen++;
    if (fill > w) fill = w;
    // full window: the entry of age w-1 leaves
    if (fill == w) begin
      pos = 0;
      while (pos < fill && win_ages[pos] != w - 1) pos++;
      if (pos < fill) begin
        for (i = pos; i < fill - 1; i++) begin
          win_vals[i] = win_vals[i + 1];
          win_ages[i] = win_ages[i + 1];
        end
        fill--;
      end
    end
    for (i = 0; i < fill; i++) win_ages[i]++;
    // equal values: new sample goes after them
    pos = 0;
    while (pos < fill && $signed(win_vals[pos]) <= $signed(x)) pos++;
    for (i = fill; i > pos; i--) begin
      win_vals[i] = win_vals[i - 1];
      win_ages[i] = win_ages[i - 1];
    end
    win_vals[pos] = x;
    win_ages[pos] = 0;
    fill++;
    if (fill == w) medians_due.insert(medians_due.size(), win_vals[(w - 1) / 2]);
  endfunction

  function void check_median(logic [31:0] got);
    logic [31:0] want;
    medians_seen++;
    if (medians_due.size() == 0) begin
      $display("%0t: median beat with none expected, expected none, actual %0d",
               $time, $signed(got));
      errors++;
    end else begin
      want = medians_due.pop_front();
      if (got !== want) begin
        $display("%0t: median mismatch, expected %0d, actual %0d",
                 $time, $signed(want), $signed(got));
        errors++;
      end
    end
  endfunction
endclass

module tb_sliding_window_median_core;

  localparam logic [2:0] ADDR_WINDOW = 3'(4 * int'(swm_pkg::REG_WINDOW_SIZE));
  // no register behind this address
  localparam logic [2:0] ADDR_SPARE  = 3'd4;
  localparam int         QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] sample
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] median

  median_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  int cfg_writes;

  sliding_window_median_core DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // monitor and watchdog, all on pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata);
      if (m_tvalid && m_tready) sb.check_median(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task send_sample(input logic [31:0] x);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending, wait out every median, then the pipeline
  task drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(int'(addr >> 2), data);
    cfg_writes++;
  endtask

  initial begin
    logic [31:0] first_run [12];
    int          win_list [6];
    int          p;
    int          n;
    int          k;
    int          cfg;
    logic [31:0] x;
    logic [31:0] noise;

    first_run = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005,
                  32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0005};
    win_list  = '{64, 1, 127, 2, 0, 65};

    sb           = new();
    quiet_cycles = 0;
    cfg_writes   = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset window of three: extremes, signs, equal values
    foreach (first_run[i]) send_sample(first_run[i]);
    drain();

    // zero acts as a window of one
    apb_write(ADDR_WINDOW, 32'h0000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    drain();

    // only the low seven bits count
    apb_write(ADDR_WINDOW, 32'hFFFF_FF82);
    send_sample(32'h0000_0007);
    send_sample(32'hFFFF_FFF9);
    send_sample(32'h0000_0007);
    send_sample(32'h8000_0000);
    drain();

    // unmapped write keeps the window filled
    apb_write(ADDR_SPARE, 32'h0000_0005);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    drain();

    for (p = 0; p < 8; p++) begin
      cfg   = (p < 6) ? win_list[p] : int'($urandom_range(1, 64));
      noise = $urandom();
      apb_write(ADDR_WINDOW, {noise[31:7], 7'(cfg)});
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (n = 0; n < 100; n++) begin
        k = $urandom_range(0, 99);
        if (k < 25) begin
          // narrow range gives many ties
          x = 32'(int'($urandom_range(0, 6)) - 3);
        end else if (k < 35) begin
          case ($urandom_range(0, 3))
            0: x = 32'h8000_0000;
            1: x = 32'h7FFF_FFFF;
            2: x = 32'h0000_0000;
            default: x = 32'hFFFF_FFFF;
          endcase
        end else begin
          x = $urandom();
        end
        send_sample(x);
      end
      drain();
    end

    $display("covered %0d samples and %0d medians over %0d register writes",
             sb.samples_seen, sb.medians_seen, cfg_writes);
    $display("windows 0 to 127 incl. saturation, idle and stall phases up to 80 in 100");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: sliding_window_median_core.f
+incdir+hdl
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/sliding_window_median_core.sv
bench/tb_sliding_window_median_core.sv
